/* design/cfht_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the context frequency hash table.
// No dependencies.
package cfht_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // action codes carried in s_tuser
    localparam logic ACT_COUNT  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // register map, index into the register list
    localparam logic REG_KEY_LENGTH = 1'b0;

    localparam logic [3:0] KEY_LENGTH_RESET = 4'd8;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

endpackage

/* design/cfht_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module cfht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/context_frequency_hash_table.sv */
`timescale 1ns / 1ps
// Context frequency hash table: FNV-1a hash, linear probing, saturating counts.
// Depends on cfht_pkg and cfht_ram.
// Steps: accept, N hash rounds (N = key length, 1..8, one multiply each), a read of the
// first slot, a key compare when it is filled, a slot read and key compare per further
// probe, then a write/result step.
// One item at a time: no new beat is taken until the last is through; an item waits in
// its write/result step while the previous result beat is not yet taken on m_tready.
// The slot-map RAM port sets the probe rate.
// Reset (aresetn low, synchronous) clears control state, then a sweep over all SLOTS
// slots empties the slot map; no beat is taken during it, register writes are.
module context_frequency_hash_table
    import cfht_pkg::*;
#(
    parameter int ENTRIES   = 4096,
    parameter int SLOTS     = 8192,   // power of two
    parameter int KEY_BYTES = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input beat
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [8*KEY_BYTES-1:0] s_tdata,   // context_key
    input  logic                   s_tuser,   // action
    // result beat
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [47:0]            m_tdata,   // hit, inserted, table_full,
                                              // entry_index[11:0], occurrences[31:0]
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int EW  = $clog2(ENTRIES);
    localparam int SW  = $clog2(SLOTS);
    localparam int UW  = $clog2(ENTRIES + 1);
    localparam int KW  = 8 * KEY_BYTES;
    localparam int EMW = KW + 32;
    localparam int SMW = EW + 1;

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_HASH     = 3'd2;
    localparam logic [2:0] ST_SLOT_RD  = 3'd3;
    localparam logic [2:0] ST_SLOT_CHK = 3'd4;
    localparam logic [2:0] ST_KEY_CHK  = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    logic [2:0]     state_reg, state_next;
    logic [3:0]     key_length_reg;
    logic [SW-1:0]  clr_reg;
    logic [UW-1:0]  used_reg;
    logic           m_tvalid_reg;
    logic [47:0]    m_tdata_reg;

    logic           action_reg;
    logic [KW-1:0]  key_reg;
    logic [KW-1:0]  hkey_reg;
    logic [3:0]     n_reg;
    logic [3:0]     hcnt_reg;
    logic [31:0]    h_reg;
    logic [SW-1:0]  slot_reg;
    logic [SW-1:0]  step_reg;
    logic [EW-1:0]  entry_reg;
    logic [KW-1:0]  skey_reg;
    logic [31:0]    cnt_reg;
    logic           found_reg;
    logic           free_found_reg;

    // RAM ports
    logic           slot_we;
    logic [SW-1:0]  slot_waddr, slot_raddr;
    logic [SMW-1:0] slot_wdata, slot_rdata;
    logic           ent_we;
    logic [EW-1:0]  ent_waddr, ent_raddr;
    logic [EMW-1:0] ent_wdata, ent_rdata;

    logic           cfg_we;
    logic           in_acc;
    logic           out_free;
    logic           finish;
    logic [3:0]     n_eff;
    logic [31:0]    h_mul;
    logic [SW-1:0]  slot_inc;
    logic           key_match;
    logic           can_ins;
    logic [31:0]    cnt_inc;
    logic           r_hit, r_ins, r_full;
    logic [EW-1:0]  r_idx;
    logic [31:0]    r_occ;

    cfht_ram #(.WIDTH(SMW), .DEPTH(SLOTS)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    cfht_ram #(.WIDTH(EMW), .DEPTH(ENTRIES)) u_entry_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // register port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_KEY_LENGTH);
    assign prdata = (paddr[2] == REG_KEY_LENGTH) ? {28'd0, key_length_reg} : 32'd0;

    always_comb begin
        n_eff = key_length_reg;
        if (key_length_reg == 4'd0) begin
            n_eff = 4'd1;
        end else if (key_length_reg > 4'(KEY_BYTES)) begin
            n_eff = 4'(KEY_BYTES);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == ST_DONE) && out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // one FNV-1a round; low 32 bits of the product
    assign h_mul    = (h_reg ^ {24'd0, hkey_reg[7:0]}) * FNV_PRIME;
    assign slot_inc = (slot_reg == SW'(SLOTS - 1)) ? '0 : slot_reg + 1'b1;

    // compare only the first n bytes
    always_comb begin
        key_match = 1'b1;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if ((4'(i) < n_reg) && (ent_rdata[32 + 8*i +: 8] != key_reg[8*i +: 8])) begin
                key_match = 1'b0;
            end
        end
    end

    // the next probe is read straight from KEY_CHK on a mismatch
    assign slot_raddr = (state_reg == ST_KEY_CHK) ? slot_inc : slot_reg;
    assign ent_raddr  = slot_rdata[EW-1:0];

    assign can_ins = !found_reg && (action_reg == ACT_COUNT) && free_found_reg
                     && (used_reg < UW'(ENTRIES));
    assign cnt_inc = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 32'd1;

    always_comb begin
        r_hit  = found_reg;
        r_ins  = can_ins;
        r_full = !found_reg && (action_reg == ACT_COUNT) && !can_ins;
        r_idx  = '0;
        r_occ  = 32'd0;
        if (found_reg) begin
            r_idx = entry_reg;
            r_occ = (action_reg == ACT_COUNT) ? cnt_inc : cnt_reg;
        end else if (can_ins) begin
            r_idx = used_reg[EW-1:0];
            r_occ = 32'd1;
        end
    end

    // memory writes: clearing sweep, or the update of a finished item
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = slot_reg;
        slot_wdata = {1'b1, used_reg[EW-1:0]};
        if (state_reg == ST_CLEAR) begin
            slot_we    = 1'b1;
            slot_waddr = clr_reg;
            slot_wdata = '0;
        end else if (finish && can_ins) begin
            slot_we = 1'b1;
        end

        ent_we    = finish && (action_reg == ACT_COUNT) && (found_reg || can_ins);
        ent_waddr = found_reg ? entry_reg : used_reg[EW-1:0];
        ent_wdata = found_reg ? {skey_reg, cnt_inc} : {key_reg, 32'd1};
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (clr_reg == SW'(SLOTS - 1)) state_next = ST_IDLE;
            ST_IDLE:     if (in_acc) state_next = ST_HASH;
            ST_HASH:     if (4'(hcnt_reg + 4'd1) == n_reg) state_next = ST_SLOT_RD;
            ST_SLOT_RD:  state_next = ST_SLOT_CHK;
            ST_SLOT_CHK: state_next = slot_rdata[SMW-1] ? ST_KEY_CHK : ST_DONE;
            ST_KEY_CHK: begin
                if (key_match || step_reg == SW'(SLOTS - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SLOT_CHK;
                end
            end
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            key_length_reg <= KEY_LENGTH_RESET;
            clr_reg        <= '0;
            used_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                key_length_reg <= pwdata[3:0];
            end
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (finish && can_ins) begin
                used_reg <= used_reg + 1'b1;
            end
            if (finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (finish) begin
            m_tdata_reg <= {1'b0, r_occ, 12'(r_idx), r_full, r_ins, r_hit};
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    action_reg     <= s_tuser;
                    key_reg        <= s_tdata;
                    hkey_reg       <= s_tdata;
                    n_reg          <= n_eff;
                    hcnt_reg       <= 4'd0;
                    h_reg          <= FNV_BASIS;
                    step_reg       <= '0;
                    found_reg      <= 1'b0;
                    free_found_reg <= 1'b0;
                end
            end
            ST_HASH: begin
                h_reg    <= h_mul;
                hkey_reg <= hkey_reg >> 8;
                hcnt_reg <= hcnt_reg + 4'd1;
                slot_reg <= h_mul[SW-1:0];
            end
            ST_SLOT_CHK: begin
                if (!slot_rdata[SMW-1]) begin
                    free_found_reg <= 1'b1;
                end
                entry_reg <= slot_rdata[EW-1:0];
            end
            ST_KEY_CHK: begin
                if (key_match) begin
                    found_reg <= 1'b1;
                    skey_reg  <= ent_rdata[EMW-1:32];
                    cnt_reg   <= ent_rdata[31:0];
                end else begin
                    slot_reg <= slot_inc;
                    step_reg <= step_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // a new entry is never reported together with a hit or a full table
    a_ins_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> !m_tdata[0] && !m_tdata[2])
        else $error("inserted beat also flags hit or table_full");

    // a full-table result carries no entry and no count
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[46:3] == 44'd0)
        else $error("table_full beat carries entry data");

    // allocation never passes the entry store
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= UW'(ENTRIES))
        else $error("entry allocation overflow");

    // each insert allocates exactly one entry
    a_used_step: assert property (@(posedge aclk) disable iff (!aresetn)
        finish && can_ins |=> used_reg == $past(used_reg) + 1'b1)
        else $error("entry count not advanced on insert");

    // no beat is taken while the slot map is being swept
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_tready)
        else $error("input taken during slot map sweep");

endmodule
